// ----- rtl/hds_pkg.sv -----
// Shared constants and types for the heat diffusion stencil step block.
`timescale 1ns / 1ps

package hds_pkg;

  // Default largest grid edge and fixed field widths.
  localparam int GRID_MAX_DEF = 128;
  localparam int GRID_MIN     = 3;
  localparam int VALUE_W      = 16;
  localparam int RATIO_W      = 15;
  localparam int SIZE_W       = 8;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [RATIO_W-1:0] RATIO_RST    = 15'd16384;
  localparam logic [VALUE_W-1:0] BOUNDARY_RST = 16'd12800;
  localparam logic [SIZE_W-1:0]  SIZE_RST     = 8'd100;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_RATIO    = 2'd0,
    REG_BOUNDARY = 2'd1,
    REG_GRID     = 2'd2
  } cfg_reg_t;

  // Per-cell control flags that travel down the pipeline with the data.
  typedef struct packed {
    logic has0;      // the cell yields the output cell one row above
    logic interior;  // that output cell is an interior cell
    logic has1;      // last input row: a border cell of the final row follows
    logic last;      // last column of the grid
  } cell_ctl_t;

endpackage

// ----- rtl/heat_diffusion_stencil_step.sv -----
// Top level of the heat diffusion stencil step: one FTCS time step per grid pass.
`timescale 1ns / 1ps

// Usage:
// Cells of the present grid enter on the in_ stream in raster order, one
// transaction per cell; in_tuser marks cell (0,0) of a grid. The next grid
// leaves on the out_ stream in raster order, one row behind the input, with
// out_tlast on its final cell. Border cells carry the boundary temperature.
// Each cell of the last input row yields two output transactions, which
// flushes the final output row.
// The cfg_ APB port holds the diffusion ratio (0x0), the boundary temperature
// (0x4) and the grid size (0x8); write it only while the block is idle.
// Each result passes through all four register stages below before it leaves
// on the out_ stream. Throughput: one cell per cycle while the receiver does
// not stall; a cell of the last input row holds the input until the first of
// its two results has left the single output register that emits both.
// The line buffers are RAMs read at the accepting edge, in step with the first
// of four register stages (neighbor sums, ratio multiply, round and saturate,
// output register).
// Reset clears the registers to their defaults and the position counters to
// cell (0,0); the line buffers need no clearing pass. When the receiver
// stalls, the whole pipeline holds and in_tready drops; nothing is lost.

module heat_diffusion_stencil_step #(
  parameter int GRID_MAX = hds_pkg::GRID_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hds_pkg::VALUE_W-1:0]       in_tdata,   // [15:0] cell_value
  input  logic                              in_tuser,   // [0] frame_start
  // Output stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hds_pkg::VALUE_W-1:0]       out_tdata,  // [15:0] new_value
  output logic                              out_tlast,  // frame_last
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [hds_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [hds_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [hds_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  import hds_pkg::*;

  localparam int AW = $clog2(GRID_MAX);
  localparam int NW = $clog2(GRID_MAX + 1);
  localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;

  // Configuration registers.
  logic [RATIO_W-1:0] ratio_r;
  logic [VALUE_W-1:0] boundary_r;
  logic [SIZE_W-1:0]  grid_size_r;
  logic               cfg_write;
  cfg_reg_t           cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r     <= RATIO_RST;
      boundary_r  <= BOUNDARY_RST;
      grid_size_r <= SIZE_RST;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_RATIO:    ratio_r     <= cfg_pwdata[RATIO_W-1:0];
        REG_BOUNDARY: boundary_r  <= cfg_pwdata[VALUE_W-1:0];
        REG_GRID:     grid_size_r <= cfg_pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_sel)
      REG_RATIO:    cfg_prdata = CFG_DATA_W'(ratio_r);
      REG_BOUNDARY: cfg_prdata = CFG_DATA_W'(boundary_r);
      REG_GRID:     cfg_prdata = CFG_DATA_W'(grid_size_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Grid size in use, clamped to the supported range.
  logic [CW-1:0] size_ext;
  logic [NW-1:0] n_cells;
  logic [NW-1:0] n_m1;

  assign size_ext = CW'(grid_size_r);

  always_comb begin
    if (size_ext < CW'(GRID_MIN)) begin
      n_cells = NW'(GRID_MIN);
    end else if (size_ext > CW'(GRID_MAX)) begin
      n_cells = NW'(GRID_MAX);
    end else begin
      n_cells = NW'(size_ext);
    end
  end

  assign n_m1 = n_cells - NW'(1);

  // Pipeline handshake: every stage moves when the output register frees up.
  logic o_pend0_r, o_pend1_r, o_last_r;
  logic [VALUE_W-1:0] o_val_r;
  logic adv, in_acc, out_acc;

  assign out_tvalid = o_pend0_r || o_pend1_r;
  assign out_acc    = out_tvalid && out_tready;
  assign adv        = !out_tvalid || (out_tready && (o_pend0_r ^ o_pend1_r));
  assign in_tready  = adv;
  assign in_acc     = in_tvalid && adv;

  // Stage 0: raster position of the incoming cell.
  logic [AW-1:0] row_r, col_r;
  logic [AW-1:0] row_nxt, col_nxt;
  logic [AW-1:0] cur_row, cur_col;
  logic [NW-1:0] col_inc, row_inc;
  logic          restart;
  cell_ctl_t     ctl0;

  assign restart = in_tuser || (NW'(row_r) >= n_cells) || (NW'(col_r) >= n_cells);
  assign cur_row = restart ? '0 : row_r;
  assign cur_col = restart ? '0 : col_r;
  assign col_inc = NW'(cur_col) + NW'(1);
  assign row_inc = NW'(cur_row) + NW'(1);

  always_comb begin
    ctl0.has0     = (cur_row != '0);
    ctl0.interior = (cur_row != AW'(1)) && (cur_col != '0) && (NW'(cur_col) != n_m1);
    ctl0.has1     = (NW'(cur_row) == n_m1);
    ctl0.last     = (NW'(cur_col) == n_m1);
  end

  always_comb begin
    if (col_inc >= n_cells) begin
      col_nxt = '0;
      row_nxt = (row_inc >= n_cells) ? '0 : row_inc[AW-1:0];
    end else begin
      col_nxt = col_inc[AW-1:0];
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Line buffers. The previous row is kept twice so that the center and the
  // right neighbor can be read in the same cycle.
  logic [VALUE_W-1:0] prev_c_rd, prev_r_rd, older_rd;
  logic               s1_valid_r, s1_fwd_r;
  cell_ctl_t          s1_ctl_r;
  logic [VALUE_W-1:0] s1_x_r, s1_left_r;
  logic [AW-1:0]      s1_col_r;

  hds_ram #(.WIDTH(VALUE_W), .DEPTH(GRID_MAX)) u_prev_center (
    .clk   (clk),
    .we    (in_acc),
    .waddr (cur_col),
    .wdata (in_tdata),
    .re    (in_acc),
    .raddr (cur_col),
    .rdata (prev_c_rd)
  );

  hds_ram #(.WIDTH(VALUE_W), .DEPTH(GRID_MAX)) u_prev_right (
    .clk   (clk),
    .we    (in_acc),
    .waddr (cur_col),
    .wdata (in_tdata),
    .re    (in_acc),
    .raddr (col_inc[AW-1:0]),
    .rdata (prev_r_rd)
  );

  // The older row takes the previous-row value once it has been read.
  hds_ram #(.WIDTH(VALUE_W), .DEPTH(GRID_MAX)) u_older (
    .clk   (clk),
    .we    (adv && s1_valid_r),
    .waddr (s1_col_r),
    .wdata (prev_c_rd),
    .re    (in_acc),
    .raddr (cur_col),
    .rdata (older_rd)
  );

  // Stage 1 registers. The left neighbor is the previous-row read of the
  // preceding cell; the same value bypasses the older row when that cell
  // writes it at the address being read in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
      s1_fwd_r   <= in_acc && s1_valid_r && (s1_col_r == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r  <= ctl0;
      s1_x_r    <= in_tdata;
      s1_col_r  <= cur_col;
      s1_left_r <= prev_c_rd;
    end
  end

  // Stage 1: five-point Laplacian.
  logic [VALUE_W-1:0]   up_val;
  logic [VALUE_W+1:0]   sum4, t4;
  logic signed [VALUE_W+2:0] lap;

  assign up_val = s1_fwd_r ? s1_left_r : older_rd;
  assign sum4   = (VALUE_W+2)'(up_val) + (VALUE_W+2)'(s1_x_r)
                + (VALUE_W+2)'(s1_left_r) + (VALUE_W+2)'(prev_r_rd);
  assign t4     = {prev_c_rd, 2'b00};
  assign lap    = $signed({1'b0, sum4}) - $signed({1'b0, t4});

  logic                      s2_valid_r;
  cell_ctl_t                 s2_ctl_r;
  logic [VALUE_W-1:0]        s2_center_r;
  logic signed [VALUE_W+2:0] s2_lap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r    <= s1_ctl_r;
      s2_center_r <= prev_c_rd;
      s2_lap_r    <= lap;
    end
  end

  // Stage 2: scale the Laplacian by the diffusion ratio.
  localparam int PW = RATIO_W + 1 + VALUE_W + 3;
  logic signed [PW-1:0] prod;

  assign prod = $signed({1'b0, ratio_r}) * s2_lap_r;

  logic                 s3_valid_r;
  cell_ctl_t            s3_ctl_r;
  logic [VALUE_W-1:0]   s3_center_r;
  logic signed [PW-1:0] s3_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctl_r    <= s2_ctl_r;
      s3_center_r <= s2_center_r;
      s3_prod_r   <= prod;
    end
  end

  // Stage 3: add the center term, round to nearest and saturate.
  localparam int TW = 36;
  logic signed [TW-1:0] total, rounded;
  logic [VALUE_W-1:0]   calc_val, cell_val;

  assign total   = $signed({4'b0000, s3_center_r, 16'h0000}) + TW'(s3_prod_r);
  assign rounded = total + TW'(32768);

  always_comb begin
    if (total[TW-1]) begin
      calc_val = '0;
    end else if (rounded[TW-1:16] > (TW-16)'(16'hFFFF)) begin
      calc_val = '1;
    end else begin
      calc_val = rounded[31:16];
    end
  end

  assign cell_val = s3_ctl_r.interior ? calc_val : boundary_r;

  // Output register: up to two results per cell, the first one first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_pend0_r <= 1'b0;
      o_pend1_r <= 1'b0;
    end else if (adv) begin
      o_pend0_r <= s3_valid_r && s3_ctl_r.has0;
      o_pend1_r <= s3_valid_r && s3_ctl_r.has1;
    end else if (out_acc) begin
      if (o_pend0_r) begin
        o_pend0_r <= 1'b0;
      end else begin
        o_pend1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_val_r  <= cell_val;
      o_last_r <= s3_ctl_r.last;
    end
  end

  assign out_tdata = o_pend0_r ? o_val_r : boundary_r;
  assign out_tlast = !o_pend0_r && o_last_r;

  // Checks on the pipeline control.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> (col_r == AW'(1)) && (row_r == '0))
    else $error("frame start did not restart the position counters");

  a_last_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !o_pend0_r && o_pend1_r)
    else $error("frame end flagged on a result other than the flush result");

  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_valid_r)
    else $error("older-row bypass set without a cell in stage 1");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input taken while the output register cannot move");

endmodule

// ----- rtl/hds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
